// ----- rtl/hysteresis_region_grow_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the hysteresis region grow block
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_REGION_GROW_MACROS_SVH
`define HYSTERESIS_REGION_GROW_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HRG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRG_ASSERT_IMP(lbl, ante, cons, msg)
`define HRG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/hrg_pkg.sv -----
// ---------------------------------------------------------------------------
// hrg_pkg
// Types, codes and constants shared by the region grow block.
// ---------------------------------------------------------------------------
`default_nettype none
package hrg_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int EW             = 13;   // covers coordinates up to 4096

  localparam logic [7:0] LOW_RESET    = 8'd85;
  localparam logic [7:0] HIGH_RESET   = 8'd135;
  localparam logic [9:0] WIDTH_RESET  = 10'd512;
  localparam logic [9:0] HEIGHT_RESET = 10'd512;

  localparam logic [1:0] REG_LOW    = 2'd0;
  localparam logic [1:0] REG_HIGH   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CLS_BG     = 2'd0;
  localparam logic [1:0] CLS_WEAK   = 2'd1;
  localparam logic [1:0] CLS_STRONG = 2'd2;

  // neighbour offset codes
  localparam logic [1:0] D_NEG  = 2'd0;
  localparam logic [1:0] D_ZERO = 2'd1;
  localparam logic [1:0] D_POS  = 2'd2;
  localparam logic [2:0] NBR_LAST = 3'd7;

  typedef struct packed {
    logic        operation;
    logic [17:0] pixel_index;
    logic [7:0]  blue_sample;
    logic        last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pixel_class;
    logic [18:0] grown_count;
    logic        growth_done;
  } out_item_t;

  typedef struct packed {
    logic        op;
    logic [17:0] idx;
    logic [1:0]  cls;
    logic        in_range;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [9:0] w;
    logic [9:0] h;
  } dims_t;

  function automatic logic [1:0] nbr_dr(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = D_NEG;
      3'd3, 3'd4:       d = D_ZERO;
      default:          d = D_POS;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nbr_dc(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = D_NEG;
      3'd1, 3'd6:       d = D_ZERO;
      default:          d = D_POS;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hysteresis_region_grow.sv -----
// ---------------------------------------------------------------------------
// hysteresis_region_grow
// 8-connected hysteresis thresholding with breadth-first region growing.
// ---------------------------------------------------------------------------
// Loads and reads are taken through start/busy into a two-entry command
// queue; every item gives exactly one result, strobed on out_valid for one
// cycle, which the receiver cannot stall. A load is written from the idle
// state and a read waits on the registered class map read. The load marked
// last also runs the grow: a scan over the class map that queues every
// strong pixel, then for each pixel taken from the growth queue a pop and a
// wait state, an address state per neighbour and a check state for each one
// inside the image, and a closing step once the queue is empty.
// busy rises only when the command queue holds two items.
// ---------------------------------------------------------------------------
`default_nettype none
module hysteresis_region_grow
  import hrg_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata,
  output logic            out_valid,
  output out_item_t       out_data
);
  dims_t dims;
  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;

  hrg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .dims(dims), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  hrg_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .dims(dims), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ----- rtl/hrg_ram.sv -----
// ---------------------------------------------------------------------------
// hrg_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module hrg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ----- rtl/hrg_front.sv -----
// ---------------------------------------------------------------------------
// hrg_front
// Config registers, sample classification and a two-entry command queue.
// ---------------------------------------------------------------------------
`default_nettype none
module hrg_front
  import hrg_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_wdata,
  output dims_t           dims,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);
  logic [7:0] low_r, high_r;
  logic [9:0] width_r, height_r;
  logic [19:0] total;
  cmd_t       new_cmd;
  cmd_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= LOW_RESET;
      high_r   <= HIGH_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW:    low_r    <= cfg_wdata[7:0];
        REG_HIGH:   high_r   <= cfg_wdata[7:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate dimensions to 1..MAX
  always_comb begin
    if (width_r == 10'd0) dims.w = 10'd1;
    else if (EW'(width_r) > EW'(MAX_WIDTH)) dims.w = 10'(MAX_WIDTH);
    else dims.w = width_r;
    if (height_r == 10'd0) dims.h = 10'd1;
    else if (EW'(height_r) > EW'(MAX_HEIGHT)) dims.h = 10'(MAX_HEIGHT);
    else dims.h = height_r;
  end

  assign total = 20'(dims.w) * 20'(dims.h);

  always_comb begin
    new_cmd.op       = in_data.operation;
    new_cmd.idx      = in_data.pixel_index;
    new_cmd.last     = in_data.last_pixel;
    new_cmd.in_range = 20'(in_data.pixel_index) < total;
    if (in_data.blue_sample < low_r) new_cmd.cls = CLS_BG;
    else if (in_data.blue_sample > high_r) new_cmd.cls = CLS_STRONG;
    else new_cmd.cls = CLS_WEAK;
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hrg_back.sv -----
// ---------------------------------------------------------------------------
// hrg_back
// Executes loads and reads on the class map and runs the breadth-first grow.
// ---------------------------------------------------------------------------
`default_nettype none
`include "hysteresis_region_grow_macros.svh"
module hrg_back
  import hrg_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire dims_t dims,
  input  wire logic  cmd_valid,
  input  wire cmd_t  cmd,
  output logic       cmd_pop,
  output logic       out_valid,
  output out_item_t  out_data
);
  localparam int MAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (MAP > 1) ? $clog2(MAP) : 1;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QW  = RW + CW;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_RD_WAIT  = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_POP      = 7'b0001000,
    S_POP_WAIT = 7'b0010000,
    S_NADDR    = 7'b0100000,
    S_NCHK     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [18:0]   total_r, total_nxt;
  logic          done_r, done_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [EW-1:0] scan_row_r, scan_row_nxt, scan_col_r, scan_col_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  logic          scan_v_r, scan_v_nxt;
  logic [QW-1:0] scan_rc_r, scan_rc_nxt;
  logic [QW-1:0] cur_rc_r, cur_rc_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [AW-1:0] n_addr_r, n_addr_nxt;
  logic [QW-1:0] n_rc_r, n_rc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [1:0]    map_wdata, map_rdata;
  logic          q_we;
  logic [QW-1:0] q_wdata, q_rdata;

  logic [1:0]      dr, dc;
  logic [EW-1:0]   nr, nc;
  logic            row_ok, col_ok, nb_ok;
  logic [2*EW-1:0] prod;

  hrg_ram #(.WIDTH(2), .DEPTH(MAP)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  hrg_ram #(.WIDTH(QW), .DEPTH(MAP)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r[AW-1:0]), .wdata(q_wdata),
    .raddr(head_r[AW-1:0]), .rdata(q_rdata)
  );

  // neighbour k of the current pixel
  always_comb begin
    dr = nbr_dr(k_r);
    dc = nbr_dc(k_r);
    nr = EW'(cur_rc_r[QW-1:CW]) + EW'(dr) - EW'(1);
    nc = EW'(cur_rc_r[CW-1:0]) + EW'(dc) - EW'(1);
    row_ok = !((dr == D_NEG) && (cur_rc_r[QW-1:CW] == '0))
          && !((dr == D_POS) && (nr >= EW'(dims.h)));
    col_ok = !((dc == D_NEG) && (cur_rc_r[CW-1:0] == '0))
          && !((dc == D_POS) && (nc >= EW'(dims.w)));
    nb_ok  = row_ok && col_ok;
    prod   = (2*EW)'(nr) * (2*EW)'(dims.w) + (2*EW)'(nc);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    total_nxt     = total_r;
    done_nxt      = done_r;
    rd_ok_nxt     = rd_ok_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    scan_addr_nxt = scan_addr_r;
    scan_v_nxt    = scan_v_r;
    scan_rc_nxt   = scan_rc_r;
    cur_rc_nxt    = cur_rc_r;
    k_nxt         = k_r;
    n_addr_nxt    = n_addr_r;
    n_rc_nxt      = n_rc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    map_we        = 1'b0;
    map_waddr     = AW'(cmd.idx);
    map_wdata     = cmd.cls;
    map_raddr     = AW'(cmd.idx);
    q_we          = 1'b0;
    q_wdata       = scan_rc_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_READ) begin
            rd_ok_nxt = cmd.in_range;
            state_nxt = S_RD_WAIT;
          end else begin
            map_we   = cmd.in_range;
            done_nxt = 1'b0;
            if (cmd.last) begin
              head_nxt      = '0;
              tail_nxt      = '0;
              total_nxt     = '0;
              scan_row_nxt  = '0;
              scan_col_nxt  = '0;
              scan_addr_nxt = '0;
              scan_v_nxt    = 1'b0;
              state_nxt     = S_SCAN;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{pixel_class: CLS_BG, grown_count: total_r,
                                growth_done: 1'b0};
            end
          end
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{pixel_class: rd_ok_r ? map_rdata : CLS_BG,
                          grown_count: total_r, growth_done: done_r};
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        map_raddr = scan_addr_r;
        // data for the previous address is back; queue it if strong
        if (scan_v_r && (map_rdata == CLS_STRONG)) begin
          q_we     = 1'b1;
          q_wdata  = scan_rc_r;
          tail_nxt = tail_r + 1'b1;
        end
        if (scan_row_r == EW'(dims.h)) begin
          scan_v_nxt = 1'b0;
          if (!scan_v_r) state_nxt = S_POP;
        end else begin
          scan_v_nxt    = 1'b1;
          scan_rc_nxt   = {scan_row_r[RW-1:0], scan_col_r[CW-1:0]};
          scan_addr_nxt = scan_addr_r + 1'b1;
          if (scan_col_r == EW'(dims.w) - EW'(1)) begin
            scan_col_nxt = '0;
            scan_row_nxt = scan_row_r + 1'b1;
          end else begin
            scan_col_nxt = scan_col_r + 1'b1;
          end
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          done_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = '{pixel_class: CLS_BG, grown_count: total_r,
                            growth_done: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          head_nxt  = head_r + 1'b1;
          total_nxt = total_r + 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_rc_nxt = q_rdata;
        k_nxt      = '0;
        state_nxt  = S_NADDR;
      end
      S_NADDR: begin
        map_raddr = prod[AW-1:0];
        if (nb_ok) begin
          n_addr_nxt = prod[AW-1:0];
          n_rc_nxt   = {nr[RW-1:0], nc[CW-1:0]};
          state_nxt  = S_NCHK;
        end else if (k_r == NBR_LAST) begin
          state_nxt = S_POP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_NCHK: begin
        map_waddr = n_addr_r;
        map_wdata = CLS_STRONG;
        if (map_rdata == CLS_WEAK) begin
          map_we   = 1'b1;
          q_we     = 1'b1;
          q_wdata  = n_rc_r;
          tail_nxt = tail_r + 1'b1;
        end
        if (k_r == NBR_LAST) begin
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_NADDR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      total_r     <= '0;
      done_r      <= 1'b0;
      scan_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      scan_v_r    <= scan_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    scan_row_r  <= scan_row_nxt;
    scan_col_r  <= scan_col_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_rc_r   <= scan_rc_nxt;
    cur_rc_r    <= cur_rc_nxt;
    k_r         <= k_nxt;
    n_addr_r    <= n_addr_nxt;
    n_rc_r      <= n_rc_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HRG_ASSERT_IMP(a_head_le_tail, 1'b1, head_r <= tail_r, "queue head passed tail")
  `HRG_ASSERT_IMP(a_pop_idle, cmd_pop, state_r == S_IDLE, "command taken while busy")
  `HRG_ASSERT_IMP(a_map_we, map_we, (state_r == S_IDLE) || (state_r == S_NCHK),
                  "map written outside load or promote")
  `HRG_ASSERT_NXT(a_cmd_prog, cmd_pop, out_valid_r || (state_r != S_IDLE),
                  "command dropped without result")
  `HRG_ASSERT_IMP(a_done_pop, $rose(done_r), $past(state_r == S_POP),
                  "done set outside queue drain")
endmodule
`default_nettype wire
